// ----- sv/sitrc_pkg.sv -----
// Shared types, constants and a helper function for the radix character converter.
`timescale 1ns / 1ps

package sitrc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX_DEF  = 16;

  localparam int CHAR_BITS     = 8;
  localparam int DIGIT_BITS    = 4;
  localparam int RADIX_BITS    = 5;
  localparam int ALPHA_BITS    = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CHUNK_BITS    = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [CHAR_BITS-1:0]  MINUS_CHAR      = 8'h2D;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN       = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_RST       = 5'd10;
  localparam logic [ALPHA_BITS-1:0] ALPHA_LOW_RST   = 64'h3736353433323130;
  localparam logic [ALPHA_BITS-1:0] ALPHA_HIGH_RST  = 64'h0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIX      = 2'd0,
    REG_ALPHA_LOW  = 2'd1,
    REG_ALPHA_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_RD,
    B_WR
  } back_state_t;

  // Look up the symbol byte of one digit in the 16-entry alphabet.
  function automatic logic [CHAR_BITS-1:0] symbol_of(
    input logic [2*ALPHA_BITS-1:0] alpha,
    input logic [DIGIT_BITS-1:0]   digit
  );
    return alpha[digit*CHAR_BITS +: CHAR_BITS];
  endfunction

endpackage

// ----- sv/sitrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sitrc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/sitrc_front.sv -----
// Input stage: accept a value, split it into sign and magnitude, register the result.
`timescale 1ns / 1ps

module sitrc_front
  import sitrc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  fr_valid,
  input  logic                  fr_take,
  output logic [VALUE_BITS:0]   fr_data
);

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS:0]   data_r;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  accept;

  // Unsigned magnitude: the most negative value wraps to 2^(VALUE_BITS-1).
  assign neg = in_value[VALUE_BITS-1];
  assign mag = neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  assign in_full   = valid_r && !fr_take;
  assign accept    = in_push && !in_full;
  assign valid_nxt = accept || (valid_r && !fr_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      data_r <= {neg, mag};
    end
  end

  assign fr_valid = valid_r;
  assign fr_data  = data_r;

endmodule

// ----- sv/sitrc_queue.sv -----
// Short FIFO between the input stage and the conversion engine.
`timescale 1ns / 1ps

module sitrc_queue
  import sitrc_pkg::*;
#(
  parameter int WIDTH = VALUE_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/sitrc_back.sv -----
// Conversion engine: digit-by-digit division by the radix, then character emission.
`timescale 1ns / 1ps

module sitrc_back
  import sitrc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  logic [VALUE_BITS:0]      q_data,
  output logic                     q_pop,
  input  logic [RADIX_BITS-1:0]    radix,
  input  logic [2*ALPHA_BITS-1:0]  alphabet,
  input  logic                     out_pop,
  output logic                     out_empty,
  output logic [CHAR_BITS-1:0]     out_char_out,
  output logic                     out_last
);

  localparam int NCHUNK = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PW     = NCHUNK * CHUNK_BITS;
  localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int NW     = $clog2(VALUE_BITS + 1);
  localparam int AW     = $clog2(VALUE_BITS);

  back_state_t            state_r, state_nxt;
  logic [PW-1:0]          work_r, work_nxt;
  logic [DIGIT_BITS-1:0]  rem_r, rem_nxt;
  logic [KW-1:0]          chunk_r, chunk_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [CHAR_BITS-1:0]   ochar_r, ochar_nxt;
  logic                   olast_r, olast_nxt;

  logic                   slot_free;
  logic                   last_chunk;
  logic [CHUNK_BITS-1:0]  qbits;
  logic [DIGIT_BITS-1:0]  rem_step;
  logic [PW-1:0]          quot;
  logic                   quot_zero;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [NW-1:0]          cnt_dec;
  logic [DIGIT_BITS-1:0]  ram_rdata;

  // One chunk of restoring division: eight remainder steps on narrow values.
  always_comb begin
    logic [DIGIT_BITS-1:0] rem;
    logic [DIGIT_BITS:0]   t;
    rem   = rem_r;
    qbits = '0;
    for (int i = 0; i < CHUNK_BITS; i++) begin
      t = {rem, work_r[PW-1-i]};
      if (t >= radix) begin
        qbits[CHUNK_BITS-1-i] = 1'b1;
        rem = DIGIT_BITS'(t - radix);
      end else begin
        rem = t[DIGIT_BITS-1:0];
      end
    end
    rem_step = rem;
  end

  assign quot       = (work_r << CHUNK_BITS) | PW'(qbits);
  assign quot_zero  = (quot == '0);
  assign last_chunk = (chunk_r == KW'(NCHUNK - 1));
  assign slot_free  = !ovalid_r || out_pop;
  assign cnt_dec    = cnt_r - NW'(1);
  assign ram_raddr  = cnt_dec[AW-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_DIV;
      end
      B_DIV: begin
        if (last_chunk && quot_zero) state_nxt = neg_r ? B_SIGN : B_RD;
      end
      B_SIGN: begin
        if (slot_free) state_nxt = B_RD;
      end
      B_RD: begin
        state_nxt = B_WR;
      end
      B_WR: begin
        if (slot_free) state_nxt = (cnt_r == NW'(1)) ? B_IDLE : B_RD;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath and output controls.
  always_comb begin
    work_nxt   = work_r;
    rem_nxt    = rem_r;
    chunk_nxt  = chunk_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_pop;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          neg_nxt   = q_data[VALUE_BITS];
          work_nxt  = PW'(q_data[VALUE_BITS-1:0]);
          rem_nxt   = '0;
          chunk_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      B_DIV: begin
        work_nxt = quot;
        if (last_chunk) begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + NW'(1);
          rem_nxt   = '0;
          chunk_nxt = '0;
        end else begin
          rem_nxt   = rem_step;
          chunk_nxt = chunk_r + KW'(1);
        end
      end
      B_SIGN: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = MINUS_CHAR;
          olast_nxt  = 1'b0;
        end
      end
      B_RD: begin
        ram_re = 1'b1;
      end
      B_WR: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = symbol_of(alphabet, ram_rdata);
          olast_nxt  = (cnt_r == NW'(1));
          cnt_nxt    = cnt_dec;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      chunk_r  <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      chunk_r  <= chunk_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    neg_r   <= neg_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  sitrc_ram #(
    .WIDTH (DIGIT_BITS),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (rem_step),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_empty    = !ovalid_r;
  assign out_char_out = ochar_r;
  assign out_last     = olast_r;

endmodule

// ----- sv/signed_int_to_radix_chars_core.sv -----
// Top level of the signed integer to radix text converter.
`timescale 1ns / 1ps

// Converts each signed VALUE_BITS-wide integer into its text form in the
// configured radix, one character byte per output transaction, most
// significant digit first, with a leading '-' for negative values and
// out_last set on the final character. The radix register saturates to the
// range 2..MAX_RADIX; digit symbols come from the two alphabet registers.
// The division engine produces each digit in ceil(VALUE_BITS/8) chunks
// (eight restoring steps per cycle against the radix), and each
// character is then fetched from the digit RAM (B_RD) and loaded into
// the output register (B_WR), which waits while the output register stays full.
// A minus sign, if any, is loaded into the output register first.
// A two-entry queue and the input register let up to three further
// numbers be accepted while one is converted.
// Configuration writes are always ready and must be made while idle.

module signed_int_to_radix_chars_core
  import sitrc_pkg::*;
#(
  parameter int MAX_RADIX  = MAX_RADIX_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [VALUE_BITS-1:0]   in_value,
  // result channel
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic [CHAR_BITS-1:0]    out_char_out,
  output logic                    out_last,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ALPHA_BITS-1:0]   cfg_data
);

  logic [RADIX_BITS-1:0] radix_r;
  logic [ALPHA_BITS-1:0] alpha_low_r;
  logic [ALPHA_BITS-1:0] alpha_high_r;
  logic [RADIX_BITS-1:0] radix_eff;
  logic                  cfg_write;

  logic                  fr_valid;
  logic                  fr_take;
  logic [VALUE_BITS:0]   fr_data;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [VALUE_BITS:0]   q_data;

  // Register file: always ready, writes to unlisted indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r      <= RADIX_RST;
      alpha_low_r  <= ALPHA_LOW_RST;
      alpha_high_r <= ALPHA_HIGH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RADIX:      radix_r      <= cfg_data[RADIX_BITS-1:0];
        REG_ALPHA_LOW:  alpha_low_r  <= cfg_data;
        REG_ALPHA_HIGH: alpha_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturate the radix into the supported range.
  always_comb begin
    radix_eff = radix_r;
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_BITS'(MAX_RADIX)) begin
      radix_eff = RADIX_BITS'(MAX_RADIX);
    end
  end

  // Front: capture and split sign from magnitude.
  sitrc_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .fr_valid (fr_valid),
    .fr_take  (fr_take),
    .fr_data  (fr_data)
  );

  // Advance the front register into the queue whenever there is room.
  assign fr_take = fr_valid && !q_full;

  sitrc_queue #(
    .WIDTH (VALUE_BITS + 1)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_take),
    .full  (q_full),
    .wdata (fr_data),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  // Back: divide into digits, then emit sign and symbols.
  sitrc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .radix        (radix_eff),
    .alphabet     ({alpha_high_r, alpha_low_r}),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

endmodule

// ----- tb/signed_int_to_radix_chars_core_tb.sv -----
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 1ps

module signed_int_to_radix_chars_core_tb;
  import sitrc_pkg::*;

  localparam int VBITS = 32;
  // Index 3 selects no register; writes to it must leave the block unchanged.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 33;

  // One character the converter should emit.
  typedef struct {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } char_beat_t;

  // One row of the directed table: a register write or a number to convert.
  // An empty text means the expected characters come from the predictor.
  typedef struct {
    bit                      is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [ALPHA_BITS-1:0]   data;
    logic [VBITS-1:0]        value;
    string                   text;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_push;
  logic                    in_full;
  logic [VBITS-1:0]        in_value;
  logic                    out_pop;
  logic                    out_empty;
  logic [CHAR_BITS-1:0]    out_char_out;
  logic                    out_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [ALPHA_BITS-1:0]   cfg_data;

  // Shadow copy of the configuration registers, updated on each write transaction.
  logic [RADIX_BITS-1:0]   sh_radix;
  logic [ALPHA_BITS-1:0]   sh_alpha_lo;
  logic [ALPHA_BITS-1:0]   sh_alpha_hi;

  char_beat_t pending_chars[$];
  plan_row_t  plan[$];
  int         mismatch_count;
  int         quiet_cycles = 0;
  bit         calm;   // set for the last part of the run: no idling on either side

  signed_int_to_radix_chars_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_value     (in_value),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_char_out (out_char_out),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Look up a digit symbol in the shadow alphabet.
  function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [3:0] d);
    if (d < 4'd8) begin
      return sh_alpha_lo[d[2:0]*8 +: 8];
    end else begin
      return sh_alpha_hi[d[2:0]*8 +: 8];
    end
  endfunction

  // Predict the characters of one number under the current shadow settings
  // and append them to the pending store.
  function automatic void format_value(input logic [VBITS-1:0] v);
    logic [VBITS-1:0] mag;
    logic [3:0]       digits[VBITS];
    int               base;
    int               n;
    char_beat_t       beat;
    base = int'(sh_radix);
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    // Two's complement negate in an unsigned word: the most negative value
    // comes out as 2^31 exactly.
    mag = v[VBITS-1] ? (~v + 1'b1) : v;
    n = 0;
    do begin
      if (n < VBITS) begin
        digits[n] = 4'(mag % base);
        n++;
      end
      mag = mag / base;
    end while (mag != 0);
    if (v[VBITS-1]) begin
      beat.ch = MINUS_CHAR;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
    end
    for (int k = n - 1; k >= 0; k--) begin
      beat.ch = digit_glyph(digits[k]);
      beat.last = (k == 0);
      pending_chars.push_back(beat);
    end
  endfunction

  // Append a typed-in expectation: last is set on its final character.
  function automatic void queue_text(input string s);
    char_beat_t beat;
    for (int i = 0; i < s.len(); i++) begin
      beat.ch = s[i];
      beat.last = (i == s.len() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                                   input logic [ALPHA_BITS-1:0] data);
    plan.push_back('{1'b1, idx, data, '0, ""});
  endfunction

  function automatic void plan_num(input logic [VBITS-1:0] v, input string s);
    plan.push_back('{1'b0, REG_RADIX, '0, v, s});
  endfunction

  // Drop push and hold until every expected character has been popped.
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Write one register while the block is idle. Valid stays high on return
  // so back-to-back writes never lower and raise it in the same step.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [ALPHA_BITS-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RADIX:      sh_radix    = data[RADIX_BITS-1:0];
      REG_ALPHA_LOW:  sh_alpha_lo = data;
      REG_ALPHA_HIGH: sh_alpha_hi = data;
      default: ;
    endcase
  endtask

  // Push one number, with an optional random gap first. Push stays high on
  // return so the next number can follow without a bubble.
  task automatic send_value(input logic [VBITS-1:0] v);
    int gap;
    cfg_valid <= 1'b0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push  <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Pick a random number: a mix of full-range words, small values,
  // extremes and values around powers of the current base.
  function automatic logic [VBITS-1:0] pick_value();
    logic [VBITS-1:0] v;
    longint           p;
    int               base;
    base = (sh_radix < 2) ? 2 : ((sh_radix > 16) ? 16 : int'(sh_radix));
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = -$urandom_range(1, 40);
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          3: v = 32'h8000_0000;
          default: v = 32'h8000_0001;
        endcase
      end
      3: begin
        p = 1;
        repeat ($urandom_range(1, 31)) begin
          if (p * base < 64'h8000_0000) p = p * base;
        end
        v = VBITS'(p) + VBITS'($urandom_range(0, 2)) - 1'b1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Result side: pop with random stall bursts, none once the run turns calm.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every popped character against the oldest expectation and keep
  // the watchdog on cycles in which no transaction happens.
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected char_out expected none actual %h last %b",
                   $time, out_char_out, out_last);
          mismatch_count++;
        end else begin
          want = pending_chars.pop_front();
          if (out_char_out !== want.ch) begin
            $display("%0t: char_out expected %h actual %h", $time, want.ch, out_char_out);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired with %0d characters outstanding",
                 $time, pending_chars.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [RADIX_BITS-1:0] radix_pick;
    int                    pause_at;
    char_beat_t            left;

    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_value       <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_RADIX;
    cfg_data       <= '0;
    mismatch_count = 0;
    calm           = 1'b0;
    sh_radix       = RADIX_RST;
    sh_alpha_lo    = ALPHA_LOW_RST;
    sh_alpha_hi    = ALPHA_HIGH_RST;

    // Directed table. At reset the upper alphabet is all zero bytes, so
    // any 8 or 9 digit comes out as a zero byte; those rows use the predictor.
    plan_num(32'd0, "0");
    plan_num(32'hFFFF_FFFF, "-1");
    plan_num(32'd1234567, "1234567");
    plan_num(32'h7FFF_FFFF, "");
    plan_num(32'h8000_0000, "");
    plan_cfg(REG_ALPHA_HIGH, 64'h4645_4443_4241_3938);
    plan_num(32'h7FFF_FFFF, "2147483647");
    plan_num(32'h8000_0000, "-2147483648");
    plan_cfg(REG_RADIX, 64'd16);
    plan_num(32'hFFFF_FFFF, "-1");
    plan_num(32'h7FFF_FFFF, "7FFFFFFF");
    plan_num(32'h8000_0000, "-80000000");
    plan_num(32'h1234_5678, "12345678");
    // Radix register values below two saturate to two.
    plan_cfg(REG_RADIX, 64'd0);
    plan_num(32'd5, "101");
    plan_num(32'h8000_0000, "");
    plan_cfg(REG_RADIX, 64'd1);
    plan_num(32'd2, "10");
    // Values above the limit saturate to sixteen.
    plan_cfg(REG_RADIX, 64'd31);
    plan_num(32'd255, "FF");
    plan_cfg(REG_RADIX, 64'd17);
    plan_num(32'd16, "10");
    plan_cfg(REG_RADIX, 64'd2);
    plan_num(32'hFFFF_FFFF, "-1");
    plan_num(32'h7FFF_FFFF, "");
    // A write to the unused index changes nothing.
    plan_cfg(REG_SPARE, '1);
    plan_num(32'd6, "110");
    // Zero bytes and duplicate symbols in the alphabet are emitted as stored.
    plan_cfg(REG_ALPHA_LOW, '0);
    plan_cfg(REG_ALPHA_HIGH, '1);
    plan_cfg(REG_RADIX, 64'd9);
    plan_num(32'd80, "");
    plan_num(-32'sd8, "");
    plan_cfg(REG_ALPHA_LOW, '1);
    plan_num(32'd7, "");

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_value(plan[i].value);
        if (plan[i].text.len() != 0) queue_text(plan[i].text);
        else format_value(plan[i].value);
      end
    end

    // Random phases, each under its own settings; the first few cover the
    // radix extremes and saturation, the last runs without idling.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: radix_pick = 5'd2;
        1: radix_pick = 5'd16;
        2: radix_pick = 5'd10;
        3: radix_pick = 5'd0;
        4: radix_pick = 5'd31;
        5: radix_pick = 5'd1;
        6: radix_pick = 5'd17;
        default: radix_pick = 5'($urandom_range(0, 31));
      endcase
      // Upper data bits are random; only the low five bits reach the register.
      write_reg(REG_RADIX, {$urandom, $urandom} & ~64'h1F | 64'(radix_pick));
      case (ph % 3)
        0: begin
          write_reg(REG_ALPHA_LOW, {$urandom, $urandom});
          write_reg(REG_ALPHA_HIGH, {$urandom, $urandom});
        end
        1: begin
          write_reg(REG_ALPHA_LOW, 64'h3736_3534_3332_3130);
          write_reg(REG_ALPHA_HIGH, 64'h6665_6463_6261_3938);
        end
        default: begin
          write_reg(REG_ALPHA_HIGH, 64'h4645_4443_4241_3938);
        end
      endcase
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      pause_at = (ph == 4) ? $urandom_range(5, PHASE_ITEMS - 5) : -1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off mid-phase until the block has emptied completely.
        if (n == pause_at) drain_results();
        send_value(pick_value());
        format_value(in_value);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_chars.size() != 0) begin
      left = pending_chars.pop_front();
      $display("%0t: missing char_out expected %h last %b actual none",
               $time, left.ch, left.last);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
